### hdl/vtk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtk_pkg;

  localparam int DEF_MAX_BINS = 16;

  localparam int BC_W    = 5;
  localparam int IDX_W   = 4;
  localparam int MU_W    = 16;
  localparam int FE_W    = 24;
  localparam int DEPTH_W = 16;
  localparam int MASK_W  = 17;
  localparam int OUT_W   = 32;
  localparam int ENTRY_W = FE_W + 2 * MU_W;
  localparam int PROD_W  = FE_W + MU_W;

  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] RECIP_LN2 = 17'd94548;
  localparam logic [OUT_W-1:0] SAT32 = '1;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_VOXEL = 1'b1
  } action_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

`default_nettype wire

### hdl/voxel_terma_kerma.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals
// cfg       in         cfg_wr_en, cfg_wr_data (bin_count)
// in        in         in_valid, in_stall, action .. mask
// out       out        out_valid, out_stall, terma_out, kerma_out, spectrum_error
//
// A voxel beat reads each used bin from memory and runs the range reduction, the
// six-step Horner chain and the sums for it, then the mask product, the 32-step ratio
// divider and the output register. A voxel beat with a zero mask goes straight to the
// output register.
// Reset clears control state and sets bin_count to 1; the table is not cleared.
// A finished result waits in the output register while the next beat is taken.
module voxel_terma_kerma #(
  parameter int MAX_BINS = vtk_pkg::DEF_MAX_BINS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [vtk_pkg::BC_W-1:0]    cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [vtk_pkg::IDX_W-1:0]   bin_index,
  input  wire logic [vtk_pkg::MU_W-1:0]    attenuation,
  input  wire logic [vtk_pkg::MU_W-1:0]    absorption,
  input  wire logic [vtk_pkg::FE_W-1:0]    weighted_fluence,
  input  wire logic [vtk_pkg::DEPTH_W-1:0] depth,
  input  wire logic [vtk_pkg::MASK_W-1:0]  mask,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [vtk_pkg::OUT_W-1:0]        terma_out,
  output logic [vtk_pkg::OUT_W-1:0]        kerma_out,
  output logic                             spectrum_error
);
  import vtk_pkg::*;

  localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW    = $clog2(MAX_BINS + 1);
  localparam int ACC_W = PROD_W + $clog2(MAX_BINS);
  localparam int KS_W  = 24 + $clog2(MAX_BINS);
  localparam int KM_W  = KS_W + MASK_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_X, S_N, S_R, S_C, S_HM, S_HD, S_EX, S_ACC,
    S_KM, S_KS, S_DW, S_TM, S_TS, S_OUT
  } state_t;

  state_t state;

  logic [BC_W-1:0]    bin_count;
  logic [CW-1:0]      used;
  logic [CW-1:0]      e;
  logic [DEPTH_W-1:0] dep;
  logic [MASK_W-1:0]  msk;

  logic [ENTRY_W-1:0] rd_data;
  logic               accept;
  logic               load_wr;

  logic [23:0]        x;
  logic [8:0]         nq;
  logic [16:0]        rr;
  logic [15:0]        r;
  logic [8:0]         n;
  logic [16:0]        t;
  logic [2:0]         k;
  logic [15:0]        ph;
  logic [15:0]        q;
  logic [16:0]        ex;
  logic [PROD_W-1:0]  fmu;
  logic [PROD_W-1:0]  fmuen;
  logic [36:0]        plo;
  logic [36:0]        phi;
  logic [57:0]        psum;
  logic [ACC_W-1:0]   t0;
  logic [ACC_W-1:0]   k0;
  logic [KS_W-1:0]    ksum;
  logic [KM_W-1:0]    km;
  logic [OUT_W-1:0]   kerma;
  logic [OUT_W-1:0]   ratio;
  logic [63:0]        tm;
  logic               err;
  logic [24:0]        nmul;
  logic [40:0]        xmul;

  div_ctl_t           dctl;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_wr  = accept && (action == ACT_LOAD) && (7'(bin_index) < 7'(MAX_BINS));
  assign used     = (7'(bin_count) > 7'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(bin_count);
  assign dctl.start = (state == S_KS);

  assign xmul = x * RECIP_LN2;
  assign nmul = nq * LN2_Q16;
  assign psum = {1'b0, phi, 20'd0} + 58'(plo);

  always_comb begin
    case (k)
      3'd1:    q = ph;
      3'd2:    q = ph >> 1;
      3'd3:    q = 16'((33'(ph) * 33'd43691) >> 17);
      3'd4:    q = ph >> 2;
      3'd5:    q = 16'((33'(ph) * 33'd52429) >> 18);
      3'd6:    q = 16'((33'(ph) * 33'd43691) >> 18);
      default: q = ph;
    endcase
  end

  vtk_spectrum_mem #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(bin_index)),
    .wr_data ({weighted_fluence, attenuation, absorption}),
    .rd_addr (e[AW-1:0]),
    .rd_data (rd_data)
  );

  vtk_divider #(
    .W (ACC_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dctl.start),
    .num   (t0),
    .den   (k0),
    .done  (dctl.done),
    .quot  (ratio)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_count <= BC_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bin_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && action == ACT_VOXEL) begin
            dep  <= depth;
            msk  <= mask;
            e    <= '0;
            t0   <= '0;
            k0   <= '0;
            ksum <= '0;
            if (mask == '0) begin
              err   <= 1'b0;
              kerma <= '0;
              state <= S_OUT;
            end else if (used == '0) begin
              state <= S_KM;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_X;
        S_X: begin
          x     <= 24'((32'(rd_data[2*MU_W-1:MU_W]) * 32'(dep)) >> 8);
          fmu   <= rd_data[ENTRY_W-1:2*MU_W] * rd_data[2*MU_W-1:MU_W];
          fmuen <= rd_data[ENTRY_W-1:2*MU_W] * rd_data[MU_W-1:0];
          state <= S_N;
        end
        S_N: begin
          nq    <= xmul[40:32];
          state <= S_R;
        end
        S_R: begin
          rr    <= 17'(25'(x) - nmul);
          state <= S_C;
        end
        S_C: begin
          if (rr >= 17'(LN2_Q16)) begin
            r <= 16'(rr - 17'(LN2_Q16));
            n <= nq + 1'b1;
          end else begin
            r <= rr[15:0];
            n <= nq;
          end
          t     <= ONE_Q16;
          k     <= 3'd6;
          state <= S_HM;
        end
        S_HM: begin
          ph    <= 16'((33'(r) * 33'(t)) >> 16);
          state <= S_HD;
        end
        S_HD: begin
          t <= ONE_Q16 - 17'(q);
          k <= k - 1'b1;
          if (k == 3'd1) begin
            state <= S_EX;
          end else begin
            state <= S_HM;
          end
        end
        S_EX: begin
          ex    <= (n >= 9'd17) ? 17'd0 : (t >> n);
          state <= S_ACC;
        end
        S_ACC: begin
          plo   <= fmuen[19:0] * ex;
          phi   <= fmuen[39:20] * ex;
          state <= S_TS;
        end
        S_TS: begin
          ksum  <= ksum + KS_W'(psum[57:32]);
          t0    <= t0 + ACC_W'(fmu);
          k0    <= k0 + ACC_W'(fmuen);
          e     <= e + 1'b1;
          if (e + 1'b1 == used) begin
            state <= S_KM;
          end else begin
            state <= S_RD;
          end
        end
        S_KM: begin
          km    <= ksum * msk;
          err   <= (t0 == '0) || (k0 == '0);
          state <= S_KS;
        end
        S_KS: begin
          kerma <= (km[KM_W-1:16] > KM_W'(SAT32)) ? SAT32 : OUT_W'(km[KM_W-1:16]);
          state <= S_DW;
        end
        S_DW: begin
          if (dctl.done) begin
            state <= S_TM;
          end
        end
        S_TM: begin
          tm    <= kerma * ratio;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            terma_out      <= (err || msk == '0) ? '0 :
                              ((tm[63:48] != '0) ? SAT32 : tm[47:16]);
            kerma_out      <= (err || msk == '0) ? '0 : kerma;
            spectrum_error <= err;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/vtk_spectrum_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module vtk_spectrum_mem #(
  parameter int DEPTH = vtk_pkg::DEF_MAX_BINS,
  parameter int AW    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [vtk_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [vtk_pkg::ENTRY_W-1:0] rd_data
);
  import vtk_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/vtk_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module vtk_divider #(
  parameter int W = 44
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [W-1:0]            num,
  input  wire logic [W-1:0]            den,
  output logic                         done,
  output logic [vtk_pkg::OUT_W-1:0]    quot
);
  import vtk_pkg::*;

  localparam int CNT_W = $clog2(OUT_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [OUT_W-1:0] low;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             ovf;

  assign ovf     = {16'd0, num} >= {den, 16'd0};
  assign shifted = {rem, low[OUT_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (ovf) begin
          quot <= SAT32;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(OUT_W);
          rem  <= W'(num >> 16);
          low  <= {num[15:0], 16'd0};
        end
      end else if (busy) begin
        low  <= {low[OUT_W-2:0], 1'b0};
        if (!diff[W]) begin
          rem <= diff[W-1:0];
        end else begin
          rem <= shifted[W-1:0];
        end
        quot <= {quot[OUT_W-2:0], !diff[W]};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### tb/vtk_checker.sv
`timescale 1ns / 1ps

module vtk_checker
  import vtk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [BC_W-1:0]    cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               action,
  input  logic [IDX_W-1:0]   bin_index,
  input  logic [MU_W-1:0]    attenuation,
  input  logic [MU_W-1:0]    absorption,
  input  logic [FE_W-1:0]    weighted_fluence,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [MASK_W-1:0]  mask,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [OUT_W-1:0]   terma_out,
  input  logic [OUT_W-1:0]   kerma_out,
  input  logic               spectrum_error,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [FE_W-1:0] fe;
    logic [MU_W-1:0] mu;
    logic [MU_W-1:0] mu_en;
  } bin_t;

  typedef struct packed {
    logic [OUT_W-1:0] terma;
    logic [OUT_W-1:0] kerma;
    logic             err;
  } dose_t;

  bin_t        spectrum [DEF_MAX_BINS];
  logic [4:0]  nbins;
  dose_t       dose_q[$];

  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] n, r, t;
    int k;
    n = x / 64'(LN2_Q16);
    r = x - n * 64'(LN2_Q16);
    t = 64'd65536;
    if (n >= 17) return 64'd0;
    for (k = 6; k >= 1; k--) t = 64'd65536 - (r * t) / (64'(k) * 64'd65536);
    return t >> n;
  endfunction

  function automatic logic [63:0] sat(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic dose_t voxel_dose(logic [DEPTH_W-1:0] d, logic [MASK_W-1:0] m);
    dose_t res;
    logic [63:0] t0, k0, ksum, fmu, fmuen, kerma, ratio, terma;
    int used;
    res = '0;
    t0 = 0;
    k0 = 0;
    ksum = 0;
    if (m == 0) return res;
    used = (nbins > DEF_MAX_BINS) ? DEF_MAX_BINS : int'(nbins);
    for (int e = 0; e < used; e++) begin
      fmu = 64'(spectrum[e].fe) * 64'(spectrum[e].mu);
      fmuen = 64'(spectrum[e].fe) * 64'(spectrum[e].mu_en);
      t0 += fmu;
      k0 += fmuen;
      ksum += (fmuen * exp_neg((64'(spectrum[e].mu) * 64'(d)) >> 8)) >> 32;
    end
    if (t0 == 0 || k0 == 0) begin
      res.err = 1'b1;
      return res;
    end
    kerma = sat((ksum * 64'(m)) >> 16);
    ratio = sat((t0 << 16) / k0);
    terma = sat((kerma * ratio) >> 16);
    res.kerma = kerma[31:0];
    res.terma = terma[31:0];
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dose_t want;
    if (rst) begin
      nbins = 5'd1;
      dose_q.delete();
    end else begin
      if (cfg_wr_en) nbins = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) spectrum[bin_index] = '{weighted_fluence, attenuation, absorption};
        else dose_q.push_back(voxel_dose(depth, mask));
      end
      if (out_valid && !out_stall) begin
        if (dose_q.size() == 0) begin
          report("unexpected result beat", 64'd0, 64'd0);
        end else begin
          want = dose_q.pop_front();
          if (terma_out !== want.terma) report("terma_out", 64'(terma_out), 64'(want.terma));
          if (kerma_out !== want.kerma) report("kerma_out", 64'(kerma_out), 64'(want.kerma));
          if (spectrum_error !== want.err)
            report("spectrum_error", 64'(spectrum_error), 64'(want.err));
        end
      end
    end
    pending = dose_q.size();
  end

endmodule

### tb/tb_voxel_terma_kerma.sv
`timescale 1ns / 1ps

module tb_voxel_terma_kerma;
  import vtk_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [BC_W-1:0]    cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  action_t            action = ACT_LOAD;
  logic [IDX_W-1:0]   bin_index = '0;
  logic [MU_W-1:0]    attenuation = '0;
  logic [MU_W-1:0]    absorption = '0;
  logic [FE_W-1:0]    weighted_fluence = '0;
  logic [DEPTH_W-1:0] depth = '0;
  logic [MASK_W-1:0]  mask = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [OUT_W-1:0]   terma_out;
  logic [OUT_W-1:0]   kerma_out;
  logic               spectrum_error;
  int                 errors;
  int                 pending;
  logic               calm = 1'b0;
  int                 hold = 0;
  logic [4:0]         counts [8] = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd17, 5'd5, 5'd1, 5'd8};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  voxel_terma_kerma u_dut (.*);

  vtk_checker u_chk (.clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall,
    .action(action), .bin_index, .attenuation, .absorption, .weighted_fluence,
    .depth, .mask, .out_valid, .out_stall, .terma_out, .kerma_out, .spectrum_error,
    .errors, .pending);

  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      hold <= 0;
    end else if (out_valid && !out_stall) begin
      n = calm ? 0 : $urandom_range(0, 3);
      hold <= n;
      out_stall <= (n > 0);
    end else if (hold > 0) begin
      hold <= hold - 1;
      out_stall <= (hold > 1);
    end
  end

  function automatic logic [31:0] pick(int w);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return (32'd1 << w) - 32'd1;
      default: return $urandom() & ((32'd1 << w) - 32'd1);
    endcase
  endfunction

  task automatic send(action_t act, logic [IDX_W-1:0] idx, logic [MU_W-1:0] mu,
                      logic [MU_W-1:0] muen, logic [FE_W-1:0] fe,
                      logic [DEPTH_W-1:0] d, logic [MASK_W-1:0] m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    bin_index <= idx;
    attenuation <= mu;
    absorption <= muen;
    weighted_fluence <= fe;
    depth <= d;
    mask <= m;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_bin(logic [IDX_W-1:0] idx, logic [MU_W-1:0] mu,
                          logic [MU_W-1:0] muen, logic [FE_W-1:0] fe);
    send(ACT_LOAD, idx, mu, muen, fe, 16'(pick(16)), 17'(pick(17)));
  endtask

  task automatic voxel(logic [DEPTH_W-1:0] d, logic [MASK_W-1:0] m);
    send(ACT_VOXEL, 4'(pick(4)), 16'(pick(16)), 16'(pick(16)), 24'(pick(24)), d, m);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_bins(logic [BC_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd1;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table first so that no bin is ever read unwritten.
    load_bin(4'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    load_bin(4'd1, 16'd0, 16'd0, 24'd0);
    for (int i = 2; i < 16; i++) load_bin(4'(i), 16'(pick(16)), 16'(pick(16)), 24'(pick(24)));
    voxel(16'd0, 17'd65536);
    voxel(16'hFFFF, 17'd1);
    voxel(16'h0100, 17'd0);
    load_bin(4'd0, 16'd0, 16'h1234, 24'h00ABCD);
    voxel(16'h0010, 17'd65536);
    load_bin(4'd0, 16'h2000, 16'd0, 24'h010000);
    voxel(16'h0010, 17'd65536);
    set_bins(5'd0);
    voxel(16'h0200, 17'd40000);

    for (int p = 0; p < 8; p++) begin
      set_bins(counts[p]);
      calm = (p % 3 == 1);
      for (int i = 0; i < 165; i++) begin
        if (p == 2 && i == 80) drain();
        if ($urandom_range(0, 9) < 3)
          load_bin(4'($urandom_range(0, 15)), 16'(pick(16)), 16'(pick(16)), 24'(pick(24)));
        else if ($urandom_range(0, 3) == 0)
          voxel(16'(pick(16)), rand_mask());
        else
          voxel(16'($urandom_range(0, 16'h0800)), rand_mask());
      end
    end

    calm = 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
